>>> src/tph_pkg.sv
// Package for the plane height pipeline: default coordinate width and beat layout constants.
// Used by triangle_plane_height; depends on nothing.
`default_nettype none
package tph_pkg;
	localparam int COORD_WIDTH_DEF = 16;
	// Eleven coordinates enter per beat, three leave.
	localparam int NUM_IN_COORDS   = 11;
	localparam int NUM_OUT_COORDS  = 3;
	// Bit positions of the flags in the result tuser.
	localparam int USER_DEGENERATE = 0;
	localparam int USER_SATURATED  = 1;
	localparam int USER_WIDTH      = 2;
	// Pipeline stages ahead of the divider: differences and products, determinant
	// terms, numerator products, numerator sum, magnitude, range check.
	localparam int FRONT_STAGES    = 6;
endpackage
`default_nettype wire

>>> src/triangle_plane_height.sv
// An accepted input beat passes the front stages, the divider stages and the output
// register, in that order, before it leaves as its result beat.
// Throughput: one beat per cycle while the output is not stalled; the divider is unrolled into one restoring
// step per pipeline stage, so a new item may enter on every clock unless the output stalls.
// A stalled output holds its stage; bubbles ahead of it are still filled.
// Reset (arst_n low) clears all valid bits; the data registers are not reset.
`default_nettype none
module triangle_plane_height #(
	parameter int COORD_WIDTH = tph_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           s_tvalid,
	output logic                                                s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, query_x, query_y (lowest first)
	input  wire logic [((tph_pkg::NUM_IN_COORDS*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                                                m_tvalid,
	input  wire logic                                           m_tready,
	// out_x, out_y, height_z (lowest first), zero padded
	output logic [((tph_pkg::NUM_OUT_COORDS*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
	// degenerate, saturated (lowest first)
	output logic [tph_pkg::USER_WIDTH-1:0]                      m_tuser
);
	localparam int W   = COORD_WIDTH;
	localparam int PW  = 2*W;        // coordinate products
	localparam int MW  = 2*W + 1;    // differences of products
	localparam int EW  = 2*W + 3;    // determinant terms e1, e2, e4
	localparam int NW  = 3*W + 6;    // numerator
	localparam int FS  = tph_pkg::FRONT_STAGES;
	localparam int NS  = FS + W + 1;
	localparam int OTW = ((tph_pkg::NUM_OUT_COORDS*W+7)/8)*8;

	logic [NS-1:0] vld_q;
	logic [NS:0]   rdy;

	assign rdy[NS] = m_tready;
	for (genvar i = 0; i < NS; i++) begin : g_rdy
		assign rdy[i] = ~vld_q[i] | rdy[i+1];
	end
	assign s_tready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) vld_q[0] <= s_tvalid;
			for (int i = 1; i < NS; i++) begin
				if (rdy[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// Input fields.
	logic signed [W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, qx, qy;
	assign ax = s_tdata[0*W +: W];
	assign ay = s_tdata[1*W +: W];
	assign az = s_tdata[2*W +: W];
	assign bx = s_tdata[3*W +: W];
	assign by = s_tdata[4*W +: W];
	assign bz = s_tdata[5*W +: W];
	assign cx = s_tdata[6*W +: W];
	assign cy = s_tdata[7*W +: W];
	assign cz = s_tdata[8*W +: W];
	assign qx = s_tdata[9*W +: W];
	assign qy = s_tdata[10*W +: W];

	// Stage 1: edge differences and the cross products of a and b.
	logic signed [W:0]    dx_s1, dyab_s1, dzab_s1;
	logic signed [PW-1:0] axbz_s1, azbx_s1, axby_s1, aybx_s1, aybz_s1, azby_s1;
	logic signed [W-1:0]  cx_s1, cy_s1, cz_s1, qx_s1, qy_s1;

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			dx_s1   <= (W+1)'(bx) - (W+1)'(ax);
			dyab_s1 <= (W+1)'(ay) - (W+1)'(by);
			dzab_s1 <= (W+1)'(az) - (W+1)'(bz);
			axbz_s1 <= PW'(ax) * PW'(bz);
			azbx_s1 <= PW'(az) * PW'(bx);
			axby_s1 <= PW'(ax) * PW'(by);
			aybx_s1 <= PW'(ay) * PW'(bx);
			aybz_s1 <= PW'(ay) * PW'(bz);
			azby_s1 <= PW'(az) * PW'(by);
			cx_s1 <= cx;
			cy_s1 <= cy;
			cz_s1 <= cz;
			qx_s1 <= qx;
			qy_s1 <= qy;
		end
	end

	// Stage 2: determinant terms.
	logic signed [EW-1:0] e1_s2, e2_s2, e4_s2;
	logic signed [MW-1:0] m3a_s2, m3b_s2, m3c_s2;
	logic signed [W-1:0]  cx_s2, cy_s2, cz_s2, qx_s2, qy_s2;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			e1_s2 <= EW'(dx_s1) * EW'(cz_s1) + EW'(dzab_s1) * EW'(cx_s1)
				+ EW'(axbz_s1) - EW'(azbx_s1);
			e2_s2 <= EW'(dyab_s1) * EW'(cz_s1) - EW'(dzab_s1) * EW'(cy_s1)
				- EW'(aybz_s1) + EW'(azby_s1);
			e4_s2 <= EW'(dx_s1) * EW'(cy_s1) + EW'(dyab_s1) * EW'(cx_s1)
				+ EW'(axby_s1) - EW'(aybx_s1);
			m3a_s2 <= MW'(axby_s1) - MW'(aybx_s1);
			m3b_s2 <= MW'(azbx_s1) - MW'(axbz_s1);
			m3c_s2 <= MW'(aybz_s1) - MW'(azby_s1);
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
			cz_s2 <= cz_s1;
			qx_s2 <= qx_s1;
			qy_s2 <= qy_s1;
		end
	end

	// Stage 3: numerator products, divisor magnitude.
	logic signed [NW-1:0] t1_s3, t2_s3, t3_s3, t4_s3, t5_s3;
	logic [EW-1:0]        den_s3;
	logic                 e4neg_s3, degen_s3;
	logic signed [W-1:0]  qx_s3, qy_s3;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			t1_s3 <= NW'(e1_s2) * NW'(qy_s2);
			t2_s3 <= NW'(e2_s2) * NW'(qx_s2);
			t3_s3 <= NW'(m3a_s2) * NW'(cz_s2);
			t4_s3 <= NW'(m3b_s2) * NW'(cy_s2);
			t5_s3 <= NW'(m3c_s2) * NW'(cx_s2);
			den_s3   <= e4_s2[EW-1] ? EW'(-e4_s2) : EW'(e4_s2);
			e4neg_s3 <= e4_s2[EW-1];
			degen_s3 <= (e4_s2 == '0);
			qx_s3 <= qx_s2;
			qy_s3 <= qy_s2;
		end
	end

	// Stage 4: numerator sum.
	logic signed [NW-1:0] num_s4;
	logic [EW-1:0]        den_s4;
	logic                 e4neg_s4, degen_s4;
	logic signed [W-1:0]  qx_s4, qy_s4;

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			num_s4   <= t1_s3 + t2_s3 + t3_s3 + t4_s3 + t5_s3;
			den_s4   <= den_s3;
			e4neg_s4 <= e4neg_s3;
			degen_s4 <= degen_s3;
			qx_s4 <= qx_s3;
			qy_s4 <= qy_s3;
		end
	end

	// Stage 5: numerator magnitude and quotient sign.
	logic [NW-1:0]       mag_s5;
	logic [EW-1:0]       den_s5;
	logic                neg_s5, degen_s5;
	logic signed [W-1:0] qx_s5, qy_s5;

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			mag_s5   <= num_s4[NW-1] ? NW'(-num_s4) : NW'(num_s4);
			neg_s5   <= num_s4[NW-1] ^ e4neg_s4;
			den_s5   <= den_s4;
			degen_s5 <= degen_s4;
			qx_s5 <= qx_s4;
			qy_s5 <= qy_s4;
		end
	end

	// Stage 6: a quotient of 2^W or more is clipped whatever its low bits are.
	logic [NW-1:0]       mag_s6;
	logic [EW-1:0]       den_s6;
	logic                neg_s6, degen_s6, big_s6;
	logic signed [W-1:0] qx_s6, qy_s6;

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			big_s6   <= ~degen_s5 & (mag_s5 >= (NW'(den_s5) << W));
			mag_s6   <= mag_s5;
			neg_s6   <= neg_s5;
			den_s6   <= den_s5;
			degen_s6 <= degen_s5;
			qx_s6 <= qx_s5;
			qy_s6 <= qy_s5;
		end
	end

	// Divider: one restoring step per stage, most significant quotient bit first.
	logic [NW-1:0]       rem_sd  [W];
	logic [W-1:0]        quo_sd  [W];
	logic [EW-1:0]       den_sd  [W];
	logic                neg_sd  [W];
	logic                degen_sd[W];
	logic                big_sd  [W];
	logic signed [W-1:0] qx_sd   [W];
	logic signed [W-1:0] qy_sd   [W];

	for (genvar k = 0; k < W; k++) begin : g_div
		logic [NW-1:0]       rem_in, shd;
		logic [W-1:0]        quo_in;
		logic [EW-1:0]       den_in;
		logic                neg_in, degen_in, big_in, take;
		logic signed [W-1:0] qx_in, qy_in;

		if (k == 0) begin : g_first
			assign rem_in   = mag_s6;
			assign quo_in   = '0;
			assign den_in   = den_s6;
			assign neg_in   = neg_s6;
			assign degen_in = degen_s6;
			assign big_in   = big_s6;
			assign qx_in    = qx_s6;
			assign qy_in    = qy_s6;
		end else begin : g_next
			assign rem_in   = rem_sd[k-1];
			assign quo_in   = quo_sd[k-1];
			assign den_in   = den_sd[k-1];
			assign neg_in   = neg_sd[k-1];
			assign degen_in = degen_sd[k-1];
			assign big_in   = big_sd[k-1];
			assign qx_in    = qx_sd[k-1];
			assign qy_in    = qy_sd[k-1];
		end

		assign shd  = NW'(den_in) << (W-1-k);
		assign take = (rem_in >= shd);

		always_ff @(posedge clk) begin
			if (rdy[FS+k]) begin
				rem_sd[k]   <= take ? rem_in - shd : rem_in;
				quo_sd[k]   <= {quo_in[W-2:0], take};
				den_sd[k]   <= den_in;
				neg_sd[k]   <= neg_in;
				degen_sd[k] <= degen_in;
				big_sd[k]   <= big_in;
				qx_sd[k]    <= qx_in;
				qy_sd[k]    <= qy_in;
			end
		end
	end

	// Output stage: clip to the coordinate range and apply the sign; a degenerate triangle gives height zero.
	logic [W-1:0] quo_f, limit_f, z_f;
	logic         sat_f;

	always_comb begin
		quo_f   = quo_sd[W-1];
		limit_f = neg_sd[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		sat_f   = 1'b0;
		z_f     = '0;
		if (!degen_sd[W-1]) begin
			if (big_sd[W-1] || (quo_f > limit_f)) begin
				sat_f = 1'b1;
				quo_f = limit_f;
			end
			z_f = neg_sd[W-1] ? W'(-quo_f) : quo_f;
		end
	end

	logic signed [W-1:0] x_out_s, y_out_s, z_out_s;
	logic                degen_out_s, sat_out_s;

	always_ff @(posedge clk) begin
		if (rdy[NS-1]) begin
			x_out_s     <= qx_sd[W-1];
			y_out_s     <= qy_sd[W-1];
			z_out_s     <= z_f;
			degen_out_s <= degen_sd[W-1];
			sat_out_s   <= sat_f;
		end
	end

	assign m_tvalid = vld_q[NS-1];
	assign m_tdata  = OTW'({z_out_s, y_out_s, x_out_s});
	assign m_tuser[tph_pkg::USER_DEGENERATE] = degen_out_s;
	assign m_tuser[tph_pkg::USER_SATURATED]  = sat_out_s;

`ifndef SYNTHESIS
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && degen_out_s |-> z_out_s == '0 && !sat_out_s)
		else $error("degenerate result with non-zero height or saturation");
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && sat_out_s |->
			z_out_s == {1'b1, {(W-1){1'b0}}} || z_out_s == {1'b0, {(W-1){1'b1}}})
		else $error("saturated height is not at a range bound");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("pipeline stalled while the output was free");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] && rdy[1] |=> vld_q[1])
		else $error("beat lost between first and second stage");
`endif
endmodule
`default_nettype wire
